[rtl/wrp_pkg.sv]
// shared types and constants for the weighted pick table
package wrp_pkg;
   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_ADD      = 2'd1,
      OP_FINALIZE = 2'd2,
      OP_DRAW     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_TOO_BIG = 2'd2,
      ST_NO_DROP = 2'd3
   } status_type;

   localparam int RATE_W = 28;
   localparam int INFO_W = 56;
   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
   localparam logic [0:0] CSR_TABLE_SIZE = 1'b0;
endpackage

[rtl/wrp_divider.sv]
// restoring divider: remainder of a 32-bit word by a 17-bit divisor, one bit a cycle
module wrp_divider
   import wrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [16:0] remainder
);
   logic [31:0] quot_ff;
   logic [17:0] rem_ff;
   logic [16:0] div_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [17:0] shifted;
   logic [17:0] diff;

   // one shift and trial subtract per cycle
   assign shifted = {rem_ff[16:0], quot_ff[31]};
   assign diff    = shifted - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd32;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (run_ff) begin
         quot_ff <= {quot_ff[30:0], 1'b0};
         rem_ff  <= diff[17] ? shifted : diff;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[16:0];
endmodule

[rtl/weighted_random_pick_table_unit.sv]
// top level of the weighted pick table: memories, sequencer and register port
//
// One item at a time; busy is high from acceptance through the result strobe,
// and also after reset while a clearing pass zeroes slots 1..DEPTH.
// An add writes its slot when it is accepted; a clear zeroes slots 1..DEPTH;
// a finalize reads then writes each slot in turn (an empty table skips this);
// a draw with no drop ends after its check. A draw runs a binary search over
// the rate memory (up to 8 steps for 256 slots), reads the entry info, then
// computes the count with a bit-serial divider, unless the count needs
// no division. The next item can be accepted in the cycle after the strobe.
// The result appears for one cycle on rsp_valid and cannot be stalled.
module weighted_random_pick_table_unit
   import wrp_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int RATE_SCALE = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [19:0] req_weight,
   input  logic [7:0]  req_item_type,
   input  logic [15:0] req_item_number,
   input  logic [15:0] req_count_min,
   input  logic [15:0] req_count_max,
   input  logic [19:0] req_rand_pick,
   input  logic [31:0] req_rand_count,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_picked_type,
   output logic [15:0] rsp_picked_number,
   output logic [15:0] rsp_picked_count,
   output logic [8:0]  rsp_picked_slot,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int AW = $clog2(DEPTH + 1);
   localparam int CW = AW + 1;
   localparam int SW = RATE_W + CW;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [RATE_W-1:0] SCALE_C = RATE_W'(RATE_SCALE);

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_FIN_RD, S_FIN_WR, S_DR_CHK, S_DR_RD, S_DR_CMP,
      S_INFO_RD, S_INFO, S_DIV, S_DONE
   } state_type;

   // memories: slot 0 is never used
   logic [RATE_W-1:0] rate_mem [DEPTH+1];
   logic [INFO_W-1:0] info_mem [DEPTH+1];
   logic [RATE_W-1:0] rate_rd_ff;
   logic [INFO_W-1:0] info_rd_ff;
   logic              rate_we, info_we;
   logic [AW-1:0]     rate_wa, rate_ra, info_wa, info_ra;
   logic [RATE_W-1:0] rate_wd;
   logic [INFO_W-1:0] info_wd;

   state_type         state_ff;
   logic              init_ff;
   logic [8:0]        tsize_ff;
   logic [CW-1:0]     wslot_ff;
   logic [CW-1:0]     idx_ff, lo_ff, hi_ff, n_ff;
   logic [SW-1:0]     sum_ff;
   logic [19:0]       pick_ff;
   logic [31:0]       rcount_ff;
   logic [1:0]        status_ff;
   logic [7:0]        ptype_ff;
   logic [15:0]       pnum_ff, pcount_ff, mn_ff;
   logic [8:0]        pslot_ff;
   logic              valid_ff;
   logic              div_start_ff;
   logic [16:0]       div_den_ff;
   logic              div_done;
   logic [16:0]       div_rem;
   logic [CW-1:0]     n_eff;
   logic [CW-1:0]     mid;
   logic [SW-1:0]     sum_in;
   logic [15:0]       mn_w, mx_w;
   logic              csr_wr;
   logic              accept;

   assign n_eff  = ({{(CW > 9 ? CW-9 : 0){1'b0}}, tsize_ff} > DEPTH_C) ? DEPTH_C
                   : CW'(tsize_ff);
   assign mid    = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign sum_in = sum_ff + SW'(rate_rd_ff);
   assign mn_w   = info_rd_ff[39:24];
   assign mx_w   = info_rd_ff[55:40];
   assign csr_wr = psel && penable && pwrite && (paddr[2] == CSR_TABLE_SIZE);
   assign accept = start && !busy;

   // memory ports
   always_ff @(posedge clock) begin
      if (rate_we) rate_mem[rate_wa] <= rate_wd;
      rate_rd_ff <= rate_mem[rate_ra];
   end
   always_ff @(posedge clock) begin
      if (info_we) info_mem[info_wa] <= info_wd;
      info_rd_ff <= info_mem[info_ra];
   end

   // memory port steering
   always_comb begin
      rate_we = 1'b0;
      info_we = 1'b0;
      rate_wa = idx_ff[AW-1:0];
      info_wa = idx_ff[AW-1:0];
      rate_wd = '0;
      info_wd = '0;
      rate_ra = idx_ff[AW-1:0];
      info_ra = hi_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept && opcode_type'(req_opcode) == OP_ADD && wslot_ff <= n_eff
                && wslot_ff != '0) begin
               rate_we = 1'b1;
               info_we = 1'b1;
               rate_wa = wslot_ff[AW-1:0];
               info_wa = wslot_ff[AW-1:0];
               rate_wd = RATE_W'(req_weight);
               info_wd = {req_count_max, req_count_min, req_item_number, req_item_type};
            end
            rate_ra = n_eff[AW-1:0];
         end
         S_CLEAR: begin
            rate_we = 1'b1;
            info_we = 1'b1;
         end
         S_FIN_WR: begin
            rate_we = 1'b1;
            rate_wd = (sum_in > SW'(RATE_MAX)) ? RATE_MAX : sum_in[RATE_W-1:0];
         end
         S_DR_RD:   rate_ra = mid[AW-1:0];
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         init_ff      <= 1'b1;
         idx_ff       <= CW'(1);
         wslot_ff     <= CW'(1);
         valid_ff     <= 1'b0;
         div_start_ff <= 1'b0;
         tsize_ff     <= '0;
      end else begin
         valid_ff     <= 1'b0;
         div_start_ff <= 1'b0;
         if (csr_wr) tsize_ff <= pwdata[8:0];
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  status_ff <= ST_OK;
                  ptype_ff  <= '0;
                  pnum_ff   <= '0;
                  pcount_ff <= '0;
                  pslot_ff  <= '0;
                  pick_ff   <= req_rand_pick;
                  rcount_ff <= req_rand_count;
                  n_ff      <= n_eff;
                  sum_ff    <= '0;
                  case (opcode_type'(req_opcode))
                     OP_CLEAR: begin
                        idx_ff   <= CW'(1);
                        wslot_ff <= CW'(1);
                        state_ff <= S_CLEAR;
                     end
                     OP_ADD: begin
                        if (wslot_ff <= n_eff && wslot_ff != '0)
                           wslot_ff <= wslot_ff + CW'(1);
                        else
                           status_ff <= ST_FULL;
                        state_ff <= S_DONE;
                     end
                     OP_FINALIZE: begin
                        idx_ff   <= CW'(1);
                        state_ff <= (n_eff == '0) ? S_DONE : S_FIN_RD;
                     end
                     default: begin
                        lo_ff    <= '0;
                        hi_ff    <= n_eff;
                        state_ff <= S_DR_CHK;
                     end
                  endcase
               end
            end
            S_CLEAR: begin
               // the pass after reset ends without a result
               idx_ff <= idx_ff + CW'(1);
               if (idx_ff == DEPTH_C) begin
                  state_ff <= init_ff ? S_IDLE : S_DONE;
                  init_ff  <= 1'b0;
               end
            end
            S_FIN_RD: state_ff <= S_FIN_WR;
            S_FIN_WR: begin
               sum_ff <= sum_in;
               idx_ff <= idx_ff + CW'(1);
               if (idx_ff == n_ff) begin
                  if (sum_in > SW'(SCALE_C)) status_ff <= ST_TOO_BIG;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_FIN_RD;
               end
            end
            S_DR_CHK: begin
               // rate_rd_ff holds the last slot's running sum
               if (n_ff == '0 || RATE_W'(pick_ff) >= rate_rd_ff) begin
                  status_ff <= ST_NO_DROP;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= (hi_ff - lo_ff > CW'(1)) ? S_DR_RD : S_INFO_RD;
               end
            end
            S_DR_RD: begin
               idx_ff   <= mid;
               state_ff <= S_DR_CMP;
            end
            S_DR_CMP: begin
               if (rate_rd_ff <= RATE_W'(pick_ff)) begin
                  lo_ff <= idx_ff;
                  state_ff <= (hi_ff - idx_ff > CW'(1)) ? S_DR_RD : S_INFO_RD;
               end else begin
                  hi_ff <= idx_ff;
                  state_ff <= (idx_ff - lo_ff > CW'(1)) ? S_DR_RD : S_INFO_RD;
               end
            end
            S_INFO_RD: state_ff <= S_INFO;
            S_INFO: begin
               ptype_ff <= info_rd_ff[7:0];
               pnum_ff  <= info_rd_ff[23:8];
               pslot_ff <= 9'(hi_ff);
               mn_ff    <= mn_w;
               if (mn_w == '0 && mx_w == '0) begin
                  pcount_ff <= '0;
                  state_ff  <= S_DONE;
               end else if (mx_w < mn_w) begin
                  pcount_ff <= mn_w;
                  state_ff  <= S_DONE;
               end else begin
                  div_den_ff   <= {1'b0, mx_w} - {1'b0, mn_w} + 17'd1;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  pcount_ff <= mn_ff + div_rem[15:0];
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   wrp_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (rcount_ff),
      .divisor   (div_den_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign busy              = (state_ff != S_IDLE) || valid_ff;
   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_picked_type   = ptype_ff;
   assign rsp_picked_number = pnum_ff;
   assign rsp_picked_count  = pcount_ff;
   assign rsp_picked_slot   = pslot_ff;
   assign prdata            = (paddr[2] == CSR_TABLE_SIZE) ? {23'd0, tsize_ff} : 32'd0;
   assign pready            = 1'b1;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while not busy");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK && rsp_picked_slot != '0)
      |-> ({1'b0, rsp_picked_slot} <= 10'(DEPTH))) else $error("slot out of range");
   a_wslot_nonzero: assert property (@(posedge clock) disable iff (reset)
      wslot_ff != '0) else $error("write slot zero");
`endif
endmodule

[tb/weighted_random_pick_table_unit_tb.sv]
// testbench for the weighted pick table: directed and random items checked against a predictor
module weighted_random_pick_table_unit_tb;
   import wrp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 256;
   localparam int SCALE = 1000000;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_CLEAR;
   logic [19:0] req_weight = '0;
   logic [7:0]  req_item_type = '0;
   logic [15:0] req_item_number = '0;
   logic [15:0] req_count_min = '0;
   logic [15:0] req_count_max = '0;
   logic [19:0] req_rand_pick = '0;
   logic [31:0] req_rand_count = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_picked_type;
   logic [15:0] rsp_picked_number;
   logic [15:0] rsp_picked_count;
   logic [8:0]  rsp_picked_slot;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  ptype;
      logic [15:0] pnumber;
      logic [15:0] pcount;
      logic [8:0]  pslot;
   } pick_result_t;

   // predictor state
   logic [27:0] rate_sum [0:SLOTS];
   logic [7:0]  slot_type [0:SLOTS];
   logic [15:0] slot_number [0:SLOTS];
   logic [15:0] slot_min [0:SLOTS];
   logic [15:0] slot_max [0:SLOTS];
   int unsigned next_slot;
   logic [8:0]  size_reg;

   pick_result_t expected_picks[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          quiet_sender = 1'b0;
   bit          run_done = 1'b0;

   weighted_random_pick_table_unit dut (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!run_done && cycle_count > CYCLE_LIMIT) begin
         $display("weighted_random_pick_table_unit test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      pick_result_t want;
      if (!reset && rsp_valid) begin
         if (expected_picks.size() == 0) begin
            report_mismatch("unexpected result", rsp_status, -1);
         end else begin
            want = expected_picks.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_picked_type !== want.ptype)
               report_mismatch("picked_type", rsp_picked_type, want.ptype);
            if (rsp_picked_number !== want.pnumber)
               report_mismatch("picked_number", rsp_picked_number, want.pnumber);
            if (rsp_picked_count !== want.pcount)
               report_mismatch("picked_count", rsp_picked_count, want.pcount);
            if (rsp_picked_slot !== want.pslot)
               report_mismatch("picked_slot", rsp_picked_slot, want.pslot);
         end
      end
   end

   function automatic void clear_table();
      for (int i = 0; i <= SLOTS; i++) begin
         rate_sum[i] = '0;
         slot_type[i] = '0;
         slot_number[i] = '0;
         slot_min[i] = '0;
         slot_max[i] = '0;
      end
      next_slot = 1;
   endfunction

   // predicts the result of one item and updates the table
   function automatic pick_result_t predict_pick(input opcode_type op, input logic [19:0] w,
         input logic [7:0] ty, input logic [15:0] num, input logic [15:0] mn,
         input logic [15:0] mx, input logic [19:0] pick, input logic [31:0] rword);
      pick_result_t r;
      int unsigned used;
      longint unsigned total;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      r = '0;
      used = (size_reg > SLOTS) ? SLOTS : size_reg;
      case (op)
         OP_CLEAR: begin
            clear_table();
         end
         OP_ADD: begin
            if (next_slot >= 1 && next_slot <= used) begin
               rate_sum[next_slot] = {8'd0, w};
               slot_type[next_slot] = ty;
               slot_number[next_slot] = num;
               slot_min[next_slot] = mn;
               slot_max[next_slot] = mx;
               next_slot++;
            end else begin
               r.status = ST_FULL;
            end
         end
         OP_FINALIZE: begin
            total = 0;
            for (int i = 1; i <= used; i++) begin
               total += rate_sum[i];
               rate_sum[i] = (total > RATE_MAX) ? RATE_MAX : total[27:0];
            end
            if (total > SCALE) r.status = ST_TOO_BIG;
         end
         default: begin
            if (used == 0 || {8'd0, pick} >= rate_sum[used]) begin
               r.status = ST_NO_DROP;
            end else begin
               lo = 0;
               hi = used;
               while (hi - lo > 1) begin
                  mid = (lo + hi) / 2;
                  if (rate_sum[mid] <= {8'd0, pick}) lo = mid;
                  else hi = mid;
               end
               r.ptype = slot_type[hi];
               r.pnumber = slot_number[hi];
               if (slot_min[hi] == 0 && slot_max[hi] == 0)
                  r.pcount = '0;
               else if (slot_max[hi] < slot_min[hi])
                  r.pcount = slot_min[hi];
               else
                  r.pcount = slot_min[hi] + 16'(rword % (32'(slot_max[hi])
                     - 32'(slot_min[hi]) + 32'd1));
               r.pslot = hi[8:0];
            end
         end
      endcase
      return r;
   endfunction

   // sends one item and records its expected result
   task automatic send_item(input opcode_type op, input logic [19:0] w = '0,
         input logic [7:0] ty = '0, input logic [15:0] num = '0,
         input logic [15:0] mn = '0, input logic [15:0] mx = '0,
         input logic [19:0] pick = '0, input logic [31:0] rword = '0);
      while (!quiet_sender && $urandom_range(99) < 15) @(posedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_weight <= w;
      req_item_type <= ty;
      req_item_number <= num;
      req_count_min <= mn;
      req_count_max <= mx;
      req_rand_pick <= pick;
      req_rand_count <= rword;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_picks.push_back(predict_pick(op, w, ty, num, mn, mx, pick, rword));
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write through the config port, only while idle
   task automatic write_table_size(input logic [8:0] value);
      wait_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {CSR_TABLE_SIZE, 2'b00};
      pwdata <= {23'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      size_reg = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      if (prdata[8:0] !== value) report_mismatch("table_size readback", prdata[8:0], value);
   endtask

   task automatic add_random(input int wmax);
      send_item(OP_ADD, 20'($urandom_range(wmax)), 8'($urandom), 16'($urandom),
         16'($urandom_range(20)), 16'($urandom_range(40)));
   endtask

   task automatic draw_random(input int pmax);
      send_item(OP_DRAW, .pick(20'($urandom_range(pmax))), .rword($urandom));
   endtask

   // extremes, every operation and the named special cases
   task automatic test_directed();
      send_item(OP_DRAW, .pick(20'd0));
      write_table_size(9'd3);
      send_item(OP_CLEAR);
      send_item(OP_ADD, 20'd0, 8'hff, 16'hffff, 16'd5, 16'd9);
      send_item(OP_ADD, 20'd1000000, 8'h00, 16'h0000, 16'hffff, 16'hffff);
      send_item(OP_ADD, 20'hfffff, 8'h5a, 16'h1234, 16'd10, 16'd2);
      send_item(OP_ADD, 20'd7);
      send_item(OP_DRAW, .pick(20'd5), .rword(32'hffffffff));
      send_item(OP_FINALIZE);
      send_item(OP_DRAW, .pick(20'd0), .rword(32'hffffffff));
      send_item(OP_DRAW, .pick(20'hfffff));
      send_item(OP_FINALIZE);
      send_item(OP_CLEAR);
      send_item(OP_ADD, 20'd0, 8'd1, 16'd1, 16'd0, 16'd0);
      send_item(OP_ADD, 20'd400000, 8'd2, 16'd2, 16'd0, 16'd0);
      send_item(OP_ADD, 20'd600000, 8'd3, 16'd3, 16'd0, 16'hffff);
      send_item(OP_FINALIZE);
      send_item(OP_DRAW, .pick(20'd0), .rword(32'd77));
      send_item(OP_DRAW, .pick(20'd399999), .rword(32'd1));
      send_item(OP_DRAW, .pick(20'd400000), .rword(32'hffffffff));
      send_item(OP_DRAW, .pick(20'd999999), .rword(32'h80000000));
      send_item(OP_DRAW, .pick(20'd1000000));
   endtask

   // random well-formed tables: clear, fill, usually finalize, many draws, some noise
   task automatic test_random_tables(input int rounds, input logic [8:0] sz);
      int n;
      write_table_size(sz);
      for (int r = 0; r < rounds; r++) begin
         send_item(OP_CLEAR);
         n = (sz > SLOTS) ? SLOTS : sz;
         n = $urandom_range(n + 1);
         for (int i = 0; i < n; i++) add_random((n > 0) ? 1000000 / (n + 1) : 1000);
         if ($urandom_range(9) != 0) send_item(OP_FINALIZE);
         for (int d = 0; d < 12; d++) draw_random(($urandom_range(3) == 0) ? 1048575 : 999999);
         if ($urandom_range(4) == 0) add_random(1048575);
      end
   endtask

   // fill the largest table, overflow it, then draw, also with a table_size above 256
   task automatic test_full_table();
      write_table_size(9'd256);
      send_item(OP_CLEAR);
      for (int i = 0; i < 256; i++) add_random(3900);
      send_item(OP_ADD, 20'd1);
      send_item(OP_FINALIZE);
      for (int d = 0; d < 20; d++) draw_random(999999);
      write_table_size(9'd511);
      for (int d = 0; d < 5; d++) draw_random(999999);
      send_item(OP_ADD, 20'hfffff);
      send_item(OP_FINALIZE);
   endtask

   initial begin
      clear_table();
      size_reg = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_tables(4, 9'd12);
      test_full_table();
      quiet_sender = 1'b1;
      test_random_tables(2, 9'd1);
      quiet_sender = 1'b0;
      test_random_tables(1, 9'd40);
      test_random_tables(1, 9'd0);
      wait_idle();
      repeat (100) @(posedge clock);
      run_done = 1'b1;
      if (error_count == 0 && expected_picks.size() == 0)
         $display("weighted_random_pick_table_unit test passed");
      else
         $display("weighted_random_pick_table_unit test failed");
      $finish;
   end
endmodule
